// File: rtl/lspd_pkg.sv
// ----------------------------------------------------------------------------
// lspd_pkg
// Shared types and constants of the lsb stego payload deframer.
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int HEADER_W = 16;
    localparam int MAGIC_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HEADER_W-1:0] HEADER_BYTES_RST = 16'd54;
    localparam logic [MAGIC_W-1:0]  MAGIC_FIRST_RST  = 8'd35;
    localparam logic [MAGIC_W-1:0]  MAGIC_SECOND_RST = 8'd42;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXTCHR  = 3'd3,
        PH_PAYLEN  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_HALT    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_EXTLEN  = 3'd0,
        KIND_EXTCHR  = 3'd1,
        KIND_PAYLEN  = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MAGIC  = 2'd1,
        ERR_EXTLEN = 2'd2
    } err_t;

    typedef struct packed {
        logic [HEADER_W-1:0] header_bytes;
        logic [MAGIC_W-1:0]  magic_first;
        logic [MAGIC_W-1:0]  magic_second;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        err_t               err;
    } result_t;

endpackage

// File: rtl/lspd_if.sv
// ----------------------------------------------------------------------------
// lspd_if
// Valid/ready channels of the deframer: image bytes in, decoded items out.
// ----------------------------------------------------------------------------
interface lspd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       frame_start;

    modport source (output valid, output pixel_byte, output frame_start, input ready);
    modport sink   (input valid, input pixel_byte, input frame_start, output ready);
endinterface

interface lspd_item_if;
    logic                         valid;
    logic                         ready;
    lspd_pkg::kind_t              item_kind;
    logic [lspd_pkg::VALUE_W-1:0] item_value;
    logic                         payload_last;
    lspd_pkg::err_t               error_code;

    modport source (output valid, output item_kind, output item_value,
                    output payload_last, output error_code, input ready);
    modport sink   (input valid, input item_kind, input item_value,
                    input payload_last, input error_code, output ready);
endinterface

// File: rtl/lsb_stego_payload_deframer.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_deframer
// Timing: a decoded item is presented in the cycle after the image byte that
// completes it is accepted.
// Throughput: one image byte per cycle, set by the combinational parser update
// feeding one output register, unless a stalled result holds off the input.
// Reset: parser returns to header skip, registers to 54, '#' and '*'.
// ----------------------------------------------------------------------------
module lsb_stego_payload_deframer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspd_pkg::CFG_DATA_W-1:0] cfg_data,
    lspd_pixel_if.sink                      pixels,
    lspd_item_if.source                     items
);

    lspd_pkg::cfg_t               cfg_reg;
    lspd_pkg::result_t            result;
    logic                         step;
    logic                         out_valid_reg, out_valid_next;
    lspd_pkg::kind_t              out_kind_reg;
    logic [lspd_pkg::VALUE_W-1:0] out_value_reg;
    logic                         out_last_reg;
    lspd_pkg::err_t               out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes <= lspd_pkg::HEADER_BYTES_RST;
            cfg_reg.magic_first  <= lspd_pkg::MAGIC_FIRST_RST;
            cfg_reg.magic_second <= lspd_pkg::MAGIC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lspd_pkg::CFG_HEADER_BYTES: cfg_reg.header_bytes <= cfg_data;
                lspd_pkg::CFG_MAGIC_FIRST:  cfg_reg.magic_first  <= cfg_data[7:0];
                lspd_pkg::CFG_MAGIC_SECOND: cfg_reg.magic_second <= cfg_data[7:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign pixels.ready = !out_valid_reg || items.ready;
    assign step         = pixels.valid && pixels.ready;

    lspd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pixel_bit   (pixels.pixel_byte[0]),
        .frame_start (pixels.frame_start),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_comb
    begin
        if (step)
        begin
            out_valid_next = result.valid;
        end
        else if (items.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_kind_reg  <= result.kind;
            out_value_reg <= result.value;
            out_last_reg  <= result.last;
            out_err_reg   <= result.err;
        end
    end

    assign items.valid        = out_valid_reg;
    assign items.item_kind    = out_kind_reg;
    assign items.item_value   = out_value_reg;
    assign items.payload_last = out_last_reg;
    assign items.error_code   = out_err_reg;

    a_err_code_on_error : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == lspd_pkg::KIND_ERROR |-> out_err_reg != lspd_pkg::ERR_NONE)
        else $error("error item without error code");

    a_no_code_otherwise : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != lspd_pkg::KIND_ERROR |-> out_err_reg == lspd_pkg::ERR_NONE)
        else $error("error code on a regular item");

    a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |->
            out_kind_reg == lspd_pkg::KIND_PAYLOAD || out_kind_reg == lspd_pkg::KIND_PAYLEN)
        else $error("payload_last on an unexpected item kind");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !items.ready |-> !pixels.ready)
        else $error("byte taken while a result is stalled");

    a_result_registered : assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid |=> out_valid_reg)
        else $error("decoded item not presented");

endmodule

// File: rtl/lspd_parser.sv
// ----------------------------------------------------------------------------
// lspd_parser
// Frame parser state: header skip, bit gathering and field decode, one image
// byte per step, with the result of the step given combinationally.
// ----------------------------------------------------------------------------
module lspd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pixel_bit,
    input  logic              frame_start,
    input  lspd_pkg::cfg_t    cfg,
    output lspd_pkg::result_t result
);

    lspd_pkg::phase_t                    phase_reg, phase_next;
    logic [lspd_pkg::HEADER_W-1:0]       header_count_reg, header_count_next;
    logic [4:0]                          bit_count_reg, bit_count_next;
    logic [lspd_pkg::VALUE_W-1:0]        bit_shift_reg, bit_shift_next;
    logic                                magic_index_reg, magic_index_next;
    logic [2:0]                          ext_remaining_reg, ext_remaining_next;
    logic [lspd_pkg::VALUE_W-1:0]        payload_remaining_reg, payload_remaining_next;

    logic                                wide;
    logic                                field_done;
    logic [lspd_pkg::VALUE_W-1:0]        value;
    logic [lspd_pkg::MAGIC_W-1:0]        magic_expect;
    logic [2:0]                          ext_dec;
    logic [lspd_pkg::VALUE_W-1:0]        pay_dec;

    always_comb
    begin
        phase_next             = phase_reg;
        header_count_next      = header_count_reg;
        bit_count_next         = bit_count_reg;
        bit_shift_next         = bit_shift_reg;
        magic_index_next       = magic_index_reg;
        ext_remaining_next     = ext_remaining_reg;
        payload_remaining_next = payload_remaining_reg;
        result                 = '0;
        result.kind            = lspd_pkg::KIND_EXTLEN;
        result.err             = lspd_pkg::ERR_NONE;
        wide                   = 1'b0;
        field_done             = 1'b0;
        value                  = '0;
        magic_expect           = '0;
        ext_dec                = '0;
        pay_dec                = '0;

        // restart on frame start
        if (frame_start)
        begin
            phase_next             = lspd_pkg::PH_HEADER;
            header_count_next      = '0;
            bit_count_next         = '0;
            bit_shift_next         = '0;
            magic_index_next       = 1'b0;
            ext_remaining_next     = '0;
            payload_remaining_next = '0;
        end

        if (phase_next == lspd_pkg::PH_HEADER)
        begin
            if (header_count_next < cfg.header_bytes)
            begin
                header_count_next = header_count_next + 1'b1;
            end
            else
            begin
                phase_next     = lspd_pkg::PH_MAGIC;
                bit_count_next = '0;
                bit_shift_next = '0;
            end
        end
        else
        begin
            header_count_next = header_count_next;
        end

        if (phase_next != lspd_pkg::PH_HEADER && phase_next != lspd_pkg::PH_HALT)
        begin
            wide = (phase_next == lspd_pkg::PH_EXTLEN) || (phase_next == lspd_pkg::PH_PAYLEN);
            bit_shift_next = {bit_shift_next[lspd_pkg::VALUE_W-2:0], pixel_bit};
            field_done = wide ? (bit_count_next == 5'd31) : (bit_count_next == 5'd7);
            if (!field_done)
            begin
                bit_count_next = bit_count_next + 5'd1;
            end
            else
            begin
                value = wide ? bit_shift_next
                             : {{(lspd_pkg::VALUE_W-8){1'b0}}, bit_shift_next[7:0]};
                bit_count_next = '0;
                bit_shift_next = '0;
                magic_expect   = magic_index_next ? cfg.magic_second : cfg.magic_first;
                ext_dec        = ext_remaining_next - 3'd1;
                pay_dec        = payload_remaining_next - 1'b1;
                result.value   = value;
                case (phase_next)
                    lspd_pkg::PH_MAGIC:
                    begin
                        if (value[7:0] != magic_expect)
                        begin
                            phase_next   = lspd_pkg::PH_HALT;
                            result.valid = 1'b1;
                            result.kind  = lspd_pkg::KIND_ERROR;
                            result.err   = lspd_pkg::ERR_MAGIC;
                        end
                        else
                        begin
                            if (magic_index_next)
                            begin
                                phase_next = lspd_pkg::PH_EXTLEN;
                            end
                            magic_index_next = ~magic_index_next;
                        end
                    end
                    lspd_pkg::PH_EXTLEN:
                    begin
                        result.valid = 1'b1;
                        if (value < 32'd2 || value > 32'd4)
                        begin
                            phase_next  = lspd_pkg::PH_HALT;
                            result.kind = lspd_pkg::KIND_ERROR;
                            result.err  = lspd_pkg::ERR_EXTLEN;
                        end
                        else
                        begin
                            ext_remaining_next = value[2:0];
                            phase_next         = lspd_pkg::PH_EXTCHR;
                            result.kind        = lspd_pkg::KIND_EXTLEN;
                        end
                    end
                    lspd_pkg::PH_EXTCHR:
                    begin
                        ext_remaining_next = ext_dec;
                        if (ext_dec == 3'd0)
                        begin
                            phase_next = lspd_pkg::PH_PAYLEN;
                        end
                        result.valid = 1'b1;
                        result.kind  = lspd_pkg::KIND_EXTCHR;
                    end
                    lspd_pkg::PH_PAYLEN:
                    begin
                        payload_remaining_next = value;
                        phase_next   = (value == '0) ? lspd_pkg::PH_HALT : lspd_pkg::PH_PAYLOAD;
                        result.valid = 1'b1;
                        result.kind  = lspd_pkg::KIND_PAYLEN;
                        result.last  = (value == '0);
                    end
                    default:
                    begin
                        payload_remaining_next = pay_dec;
                        if (pay_dec == '0)
                        begin
                            phase_next  = lspd_pkg::PH_HALT;
                            result.last = 1'b1;
                        end
                        result.valid = 1'b1;
                        result.kind  = lspd_pkg::KIND_PAYLOAD;
                    end
                endcase
            end
        end

        result.valid = result.valid & step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= lspd_pkg::PH_HEADER;
            header_count_reg      <= '0;
            bit_count_reg         <= '0;
            bit_shift_reg         <= '0;
            magic_index_reg       <= 1'b0;
            ext_remaining_reg     <= '0;
            payload_remaining_reg <= '0;
        end
        else if (step)
        begin
            phase_reg             <= phase_next;
            header_count_reg      <= header_count_next;
            bit_count_reg         <= bit_count_next;
            bit_shift_reg         <= bit_shift_next;
            magic_index_reg       <= magic_index_next;
            ext_remaining_reg     <= ext_remaining_next;
            payload_remaining_reg <= payload_remaining_next;
        end
    end

endmodule

// File: sim/lsb_stego_payload_deframer_test.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_deframer_test
// Streams stego images into the deframer and checks every decoded item.
// A directed table of frames covers the reset settings, the magic and
// extension length errors, zero and huge payload lengths and the header
// extremes. Random frames follow, mostly well formed with random content,
// some corrupted, truncated or mixed with noise, under several register
// settings. Every accepted byte runs through a local parser model whose
// items are compared in order with the block's output, while the sender
// pauses in bursts and the receiver stalls, twice for a long stretch.
// ----------------------------------------------------------------------------
module lsb_stego_payload_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 200;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE       = 3;
    localparam int unsigned ALL_BITS     = 32'hFFFF_FFFF;
    localparam int unsigned MAGIC_BITS   = 16;
    localparam int unsigned EXTLEN_BITS  = 48;

    localparam logic [15:0] RST_HDR = lspd_pkg::HEADER_BYTES_RST;
    localparam logic [7:0]  RST_M1  = lspd_pkg::MAGIC_FIRST_RST;
    localparam logic [7:0]  RST_M2  = lspd_pkg::MAGIC_SECOND_RST;

    typedef struct {
        lspd_pkg::kind_t kind;
        logic [31:0]     value;
        logic            last;
        lspd_pkg::err_t  err;
    } decoded_t;

    typedef struct {
        logic        start;
        int unsigned hdr;
        logic [7:0]  m1;
        logic [7:0]  m2;
        logic [31:0] ext_len;
        int unsigned n_ext;
        logic [31:0] pay_len;
        int unsigned n_pay;
        int unsigned bit_cap;
        int unsigned tail;
    } frame_t;

    typedef struct {
        logic           set_cfg;
        logic [15:0]    c_hdr;
        logic [7:0]     c_m1;
        logic [7:0]     c_m2;
        logic           start;
        int unsigned    hdr;
        logic [7:0]     m1;
        logic [7:0]     m2;
        logic [31:0]    ext_len;
        int unsigned    n_ext;
        logic [31:0]    pay_len;
        int unsigned    n_pay;
        int unsigned    tail;
        lspd_pkg::err_t want_err;
        logic [31:0]    want_val;
    } directed_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lspd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lspd_pkg::CFG_DATA_W-1:0] cfg_data;

    lspd_pixel_if pix();
    lspd_item_if  items();

    // settings and parser state of the local model
    logic [15:0]      cfg_header;
    logic [7:0]       cfg_magic_first;
    logic [7:0]       cfg_magic_second;
    lspd_pkg::phase_t parse_phase;
    logic [15:0]      skipped;
    logic [4:0]       bits_in;
    logic [31:0]      shifter;
    logic             magic_sel;
    logic [2:0]       ext_left;
    logic [31:0]      pay_left;

    decoded_t       expected_items [$];
    int             mismatches = 0;
    int unsigned    live_bytes = 0;
    int unsigned    burst_left = 0;
    bit             hold_req   = 1'b0;
    lspd_pkg::err_t typed_err  = lspd_pkg::ERR_NONE;
    logic [31:0]    typed_val  = 32'd0;

    directed_t directed_frames [11] = '{
        // no frame_start after reset, reset settings
        '{1'b0, RST_HDR, RST_M1, RST_M2, 1'b0, 54, RST_M1, RST_M2,
          32'd2, 2, 32'd1, 1, 0, lspd_pkg::ERR_NONE, 32'd0},
        '{1'b1, 16'd2, RST_M1, RST_M2, 1'b1, 2, 8'h24, RST_M2,
          32'd3, 3, 32'd4, 4, 2, lspd_pkg::ERR_MAGIC, 32'h24},
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, 8'h00,
          32'd3, 3, 32'd4, 4, 2, lspd_pkg::ERR_MAGIC, 32'h00},
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, RST_M2,
          32'd5, 5, 32'd1, 1, 2, lspd_pkg::ERR_EXTLEN, 32'd5},
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, RST_M2,
          32'd1, 1, 32'd1, 1, 2, lspd_pkg::ERR_EXTLEN, 32'd1},
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, RST_M2,
          32'hFFFF_FFFF, 2, 32'd1, 1, 2, lspd_pkg::ERR_EXTLEN, 32'hFFFF_FFFF},
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, RST_M2,
          32'd0, 0, 32'd1, 1, 2, lspd_pkg::ERR_EXTLEN, 32'd0},
        // zero payload length closes the frame
        '{1'b0, 16'd2, RST_M1, RST_M2, 1'b1, 2, RST_M1, RST_M2,
          32'd2, 2, 32'd0, 0, 0, lspd_pkg::ERR_NONE, 32'd0},
        // zero header
        '{1'b1, 16'd0, 8'h00, 8'hFF, 1'b1, 0, 8'h00, 8'hFF,
          32'd4, 4, 32'd1, 1, 0, lspd_pkg::ERR_NONE, 32'd0},
        // largest payload length, cut short by the next frame
        '{1'b1, 16'd0, 8'hFF, 8'h00, 1'b1, 0, 8'hFF, 8'h00,
          32'd2, 2, 32'hFFFF_FFFF, 1, 0, lspd_pkg::ERR_NONE, 32'd0},
        // largest header swallows the whole frame
        '{1'b1, 16'hFFFF, RST_M1, RST_M2, 1'b1, 0, RST_M1, RST_M2,
          32'd2, 2, 32'd0, 0, 0, lspd_pkg::ERR_NONE, 32'd0}
    };

    lsb_stego_payload_deframer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .items     (items)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic clear_parser();
        parse_phase = lspd_pkg::PH_HEADER;
        skipped     = '0;
        bits_in     = '0;
        shifter     = '0;
        magic_sel   = 1'b0;
        ext_left    = '0;
        pay_left    = '0;
    endtask

    task automatic decode_pixel(input logic [7:0] pb, input logic fs,
                                output bit got, output decoded_t r);
        logic [31:0] word;
        int unsigned width;
        got = 1'b0;
        r   = '{lspd_pkg::KIND_EXTLEN, 32'd0, 1'b0, lspd_pkg::ERR_NONE};
        if (fs)
            clear_parser();
        if (parse_phase == lspd_pkg::PH_HEADER)
        begin
            if (skipped < cfg_header)
            begin
                skipped++;
                return;
            end
            parse_phase = lspd_pkg::PH_MAGIC;
            bits_in     = '0;
            shifter     = '0;
        end
        if (parse_phase == lspd_pkg::PH_HALT)
            return;
        width   = (parse_phase == lspd_pkg::PH_EXTLEN ||
                   parse_phase == lspd_pkg::PH_PAYLEN) ? 32 : 8;
        shifter = {shifter[30:0], pb[0]};
        if (bits_in + 1 < width)
        begin
            bits_in++;
            return;
        end
        word    = (width == 8) ? {24'd0, shifter[7:0]} : shifter;
        bits_in = '0;
        shifter = '0;
        got     = 1'b1;
        case (parse_phase)
            lspd_pkg::PH_MAGIC:
            begin
                if (word[7:0] != (magic_sel ? cfg_magic_second : cfg_magic_first))
                begin
                    parse_phase = lspd_pkg::PH_HALT;
                    r = '{lspd_pkg::KIND_ERROR, word, 1'b0, lspd_pkg::ERR_MAGIC};
                end
                else
                begin
                    got = 1'b0;
                    if (magic_sel)
                        parse_phase = lspd_pkg::PH_EXTLEN;
                    magic_sel = ~magic_sel;
                end
            end
            lspd_pkg::PH_EXTLEN:
            begin
                if (word < 2 || word > 4)
                begin
                    parse_phase = lspd_pkg::PH_HALT;
                    r = '{lspd_pkg::KIND_ERROR, word, 1'b0, lspd_pkg::ERR_EXTLEN};
                end
                else
                begin
                    ext_left    = word[2:0];
                    parse_phase = lspd_pkg::PH_EXTCHR;
                    r = '{lspd_pkg::KIND_EXTLEN, word, 1'b0, lspd_pkg::ERR_NONE};
                end
            end
            lspd_pkg::PH_EXTCHR:
            begin
                ext_left--;
                if (ext_left == 0)
                    parse_phase = lspd_pkg::PH_PAYLEN;
                r = '{lspd_pkg::KIND_EXTCHR, word, 1'b0, lspd_pkg::ERR_NONE};
            end
            lspd_pkg::PH_PAYLEN:
            begin
                pay_left    = word;
                parse_phase = (word == 0) ? lspd_pkg::PH_HALT : lspd_pkg::PH_PAYLOAD;
                r = '{lspd_pkg::KIND_PAYLEN, word, word == 0, lspd_pkg::ERR_NONE};
            end
            default:
            begin
                pay_left--;
                if (pay_left == 0)
                    parse_phase = lspd_pkg::PH_HALT;
                r = '{lspd_pkg::KIND_PAYLOAD, word, pay_left == 0, lspd_pkg::ERR_NONE};
            end
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] pb, input logic fs);
        int unsigned gap;
        bit          got;
        decoded_t    r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        // hold the request until it is taken
        pix.valid       <= 1'b1;
        pix.pixel_byte  <= pb;
        pix.frame_start <= fs;
        do @(posedge clk); while (!pix.ready);
        if (fs || parse_phase != lspd_pkg::PH_HALT)
            live_bytes++;
        decode_pixel(pb, fs, got, r);
        if (got)
        begin
            if (r.kind == lspd_pkg::KIND_ERROR && typed_err != lspd_pkg::ERR_NONE)
            begin
                r.value = typed_val;
                r.err   = typed_err;
            end
            expected_items.push_back(r);
        end
    endtask

    task automatic send_frame(input frame_t f);
        logic [7:0]  hidden [$];
        logic        mark;
        int unsigned sent;
        mark   = f.start;
        sent   = 0;
        hidden = {f.m1, f.m2, f.ext_len[31:24], f.ext_len[23:16], f.ext_len[15:8],
                  f.ext_len[7:0]};
        repeat (f.n_ext) hidden.push_back(8'($urandom));
        hidden.push_back(f.pay_len[31:24]);
        hidden.push_back(f.pay_len[23:16]);
        hidden.push_back(f.pay_len[15:8]);
        hidden.push_back(f.pay_len[7:0]);
        repeat (f.n_pay) hidden.push_back(8'($urandom));
        repeat (f.hdr)
        begin
            send_pixel(8'($urandom), mark);
            mark = 1'b0;
        end
        foreach (hidden[i])
        begin
            for (int b = 7; b >= 0; b--)
            begin
                if (sent < f.bit_cap)
                begin
                    send_pixel({7'($urandom), hidden[i][b]}, mark);
                    mark = 1'b0;
                    sent++;
                end
            end
        end
        repeat (f.tail) send_pixel(8'($urandom), 1'b0);
    endtask

    task automatic program_regs(input logic [15:0] h, input logic [7:0] a,
                                input logic [7:0] b);
        pix.valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lspd_pkg::CFG_HEADER_BYTES;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= lspd_pkg::CFG_MAGIC_FIRST;
        cfg_data  <= {8'($urandom), a};
        @(posedge clk);
        cfg_index <= lspd_pkg::CFG_MAGIC_SECOND;
        cfg_data  <= {8'($urandom), b};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_header       = h;
        cfg_magic_first  = a;
        cfg_magic_second = b;
    endtask

    initial
    begin : item_sink
        logic [7:0]  pat;
        int unsigned mode;
        int unsigned span;
        items.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                items.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
                pat  = 8'($urandom) | 8'h01;
                repeat (span)
                begin
                    case (mode)
                        0: items.ready <= 1'b1;
                        1: items.ready <= 1'($urandom);
                        2: items.ready <= ($urandom_range(0, 7) != 0);
                        default:
                        begin
                            items.ready <= pat[0];
                            pat = {pat[0], pat[7:1]};
                        end
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : item_check
        decoded_t want;
        if (rst_n && items.valid && items.ready)
        begin
            if (expected_items.size() == 0)
            begin
                $display("%0t: unexpected item: kind %0d value %h last %0b err %0d", $time,
                         items.item_kind, items.item_value, items.payload_last,
                         items.error_code);
                mismatches++;
            end
            else
            begin
                want = expected_items.pop_front();
                if (items.item_kind !== want.kind || items.item_value !== want.value ||
                    items.payload_last !== want.last || items.error_code !== want.err)
                begin
                    $display("%0t: expected kind %0d value %h last %0b err %0d", $time,
                             want.kind, want.value, want.last, want.err);
                    $display("%0t:   actual kind %0d value %h last %0b err %0d", $time,
                             items.item_kind, items.item_value, items.payload_last,
                             items.error_code);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        frame_t      f;
        logic [15:0] new_hdr;
        int unsigned phase_frames;
        int unsigned cap;
        bit          second_hold;
        phase_frames = 0;
        second_hold  = 1'b0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= lspd_pkg::CFG_HEADER_BYTES;
        cfg_data        <= '0;
        pix.valid       <= 1'b0;
        pix.pixel_byte  <= '0;
        pix.frame_start <= 1'b0;
        cfg_header       = lspd_pkg::HEADER_BYTES_RST;
        cfg_magic_first  = lspd_pkg::MAGIC_FIRST_RST;
        cfg_magic_second = lspd_pkg::MAGIC_SECOND_RST;
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_frames[i])
        begin
            if (directed_frames[i].set_cfg)
                program_regs(directed_frames[i].c_hdr, directed_frames[i].c_m1,
                             directed_frames[i].c_m2);
            typed_err = directed_frames[i].want_err;
            typed_val = directed_frames[i].want_val;
            // stop an error frame right after the offending field
            cap = ALL_BITS;
            if (directed_frames[i].want_err == lspd_pkg::ERR_MAGIC)
                cap = MAGIC_BITS;
            else if (directed_frames[i].want_err == lspd_pkg::ERR_EXTLEN)
                cap = EXTLEN_BITS;
            f = '{directed_frames[i].start, directed_frames[i].hdr, directed_frames[i].m1,
                  directed_frames[i].m2, directed_frames[i].ext_len, directed_frames[i].n_ext,
                  directed_frames[i].pay_len, directed_frames[i].n_pay, cap,
                  directed_frames[i].tail};
            send_frame(f);
            typed_err = lspd_pkg::ERR_NONE;
        end

        live_bytes = 0;
        hold_req   = 1'b1;
        while (live_bytes < RANDOM_BYTES)
        begin
            if (phase_frames == 0)
            begin
                case ($urandom_range(0, 5))
                    0: new_hdr = 16'd0;
                    1: new_hdr = 16'd1;
                    2: new_hdr = lspd_pkg::HEADER_BYTES_RST;
                    default: new_hdr = 16'($urandom_range(2, 10));
                endcase
                program_regs(new_hdr,
                             ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom),
                             ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
                phase_frames = $urandom_range(1, 3);
            end
            phase_frames--;
            if (!second_hold && live_bytes > RANDOM_BYTES / 2)
            begin
                hold_req    = 1'b1;
                second_hold = 1'b1;
            end

            f.start   = 1'b1;
            f.hdr     = 32'(cfg_header);
            f.m1      = cfg_magic_first;
            f.m2      = cfg_magic_second;
            f.ext_len = $urandom_range(2, 4);
            f.n_ext   = f.ext_len;
            if ($urandom_range(0, 9) == 0)
            begin
                f.pay_len = $urandom;
                f.n_pay   = $urandom_range(0, 6);
            end
            else
            begin
                f.pay_len = $urandom_range(0, 12);
                f.n_pay   = f.pay_len;
            end
            f.bit_cap = ALL_BITS;
            f.tail    = $urandom_range(0, 3);
            // corrupted, misaligned, truncated or noisy variants
            case ($urandom_range(0, 9))
                0:
                begin
                    if ($urandom_range(0, 1))
                        f.m1 = 8'($urandom);
                    else
                        f.m2 = 8'($urandom);
                end
                1:
                begin
                    f.ext_len = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
                    f.n_ext   = 2;
                end
                2: f.hdr = (cfg_header == 0 || $urandom_range(0, 1)) ? cfg_header + 1
                                                                     : cfg_header - 1;
                3: f.bit_cap = $urandom_range(0, 100);
                4: repeat ($urandom_range(1, 40))
                       send_pixel(8'($urandom), $urandom_range(0, 7) == 0);
                default: ;
            endcase
            send_frame(f);
        end

        pix.valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: lsb_stego_payload_deframer.f
rtl/lspd_pkg.sv
rtl/lspd_if.sv
rtl/lspd_parser.sv
rtl/lsb_stego_payload_deframer.sv
sim/lsb_stego_payload_deframer_test.sv
